// ===== hdl/pnrf_pkg.sv =====
// Shared types, command and status codes for the per-node ring feed core.
`default_nettype none
package pnrf_pkg;

  // Command codes on the input channel
  typedef enum logic [3:0] {
    CMD_CREATE  = 4'd0,
    CMD_SHARE   = 4'd1,
    CMD_CASCADE = 4'd2,
    CMD_PUSH    = 4'd3,
    CMD_INSERT  = 4'd4,
    CMD_POP     = 4'd5,
    CMD_ROTATE  = 4'd6,
    CMD_SEARCH  = 4'd7,
    CMD_DROP    = 4'd8,
    CMD_READ    = 4'd9
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_ITEM   = 3'd1,
    ST_DEAD      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_UNDERFLOW = 3'd5
  } status_t;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // One row of the item table
  typedef struct packed {
    logic [15:0] refs;
    logic [15:0] shares;
    logic [15:0] casc;
    logic [31:0] birth;
    logic [31:0] death;
  } item_t;

  // Saturating counter increment
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    logic [15:0] r;
    r = (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/per_node_ring_feed_with_refcount_core.sv =====
// Per-node ring feeds of item ids with a reference-counted item table.
// Sequence: decode, then result, for create/share/cascade/drop/read and non-evicting
//   push/insert; pop and rotate add a feed read; evicting push/insert add a feed read
//   and, if the evicted id exists, an item update; search reads one feed entry per step.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: feeds empty, item count zero, feed_length 16; memories are not cleared.
`default_nettype none
module per_node_ring_feed_with_refcount_core #(
  parameter int NODES      = 64,
  parameter int FEED_DEPTH = 16,
  parameter int ITEMS      = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_command,
  input  wire logic [5:0]  in_node,
  input  wire logic [9:0]  in_item_id,
  input  wire logic [31:0] in_tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [9:0]       out_item_out,
  output logic             out_found,
  output logic [4:0]       out_feed_fill,
  output logic [15:0]      out_live_refs,
  output logic [15:0]      out_share_count,
  output logic [15:0]      out_cascade_count,
  output logic [31:0]      out_birth_tick,
  output logic [31:0]      out_death_tick,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_feed_length
);

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW  = (FEED_DEPTH > 1) ? $clog2(FEED_DEPTH) : 1;
  localparam int CW  = $clog2(FEED_DEPTH + 1);
  localparam int XW  = CW + 1;
  localparam int FD  = NODES * FEED_DEPTH;
  localparam int FW  = (FD > 1) ? $clog2(FD) : 1;
  localparam int IW  = $clog2(ITEMS);
  localparam int NCW = $clog2(ITEMS + 1);
  localparam int HCW = SW + CW;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_FDAT, S_EDAT, S_OUT} state_t;

  state_t                  state_r;
  pnrf_pkg::cmd_t          cmd_r;
  logic [NW-1:0]           v_r;
  logic [9:0]              id_r;
  logic [31:0]             tick_r;
  logic [SW-1:0]           h_r;
  logic [CW-1:0]           c_r;
  logic [SW-1:0]           slot_r;
  logic [CW-1:0]           j_r;
  logic [9:0]              ev_r;
  logic [NCW-1:0]          cnt_r;
  logic [4:0]              feed_length_r;
  logic [NODES-1:0]        node_vld_r;
  pnrf_pkg::status_t       status_r;
  logic [9:0]              item_out_r;
  logic                    found_r;
  logic [CW-1:0]           fill_r;
  pnrf_pkg::item_t         res_item_r;
  logic                    out_valid_r;
  logic [2:0]              out_status_r;
  logic [9:0]              out_item_out_r;
  logic                    out_found_r;
  logic [4:0]              out_fill_r;
  pnrf_pkg::item_t         out_item_r;

  // Node index reduction table
  logic [NW-1:0] node_mod [64];
  for (genvar gi = 0; gi < 64; gi++) begin : g_nmod
    assign node_mod[gi] = NW'(gi % NODES);
  end

  // Effective feed length
  logic [CW-1:0] len;
  always_comb begin
    if (feed_length_r == 5'd0) begin
      len = CW'(1);
    end else if ({4'd0, feed_length_r} > 9'(FEED_DEPTH)) begin
      len = CW'(FEED_DEPTH);
    end else begin
      len = CW'(feed_length_r);
    end
  end

  // Memory ports
  logic           hc_we;
  logic [HCW-1:0] hc_q;
  logic [NW-1:0]  hc_raddr;
  logic           f_we;
  logic [SW-1:0]  f_wslot, f_rslot;
  logic [9:0]     f_wdata, feed_q;
  logic [FW-1:0]  f_waddr, f_raddr;
  logic           it_we;
  logic [IW-1:0]  it_waddr, it_raddr;
  pnrf_pkg::item_t it_wdata, item_q;
  logic [SW-1:0]  nh;
  logic [CW-1:0]  nc;

  pnrf_ram #(.W(HCW), .D(NODES), .AW(NW)) u_hc_ram (
    .clk, .we(hc_we), .waddr(v_r), .wdata({nh, nc}), .raddr(hc_raddr), .rdata(hc_q)
  );

  pnrf_ram #(.W(10), .D(FD), .AW(FW)) u_feed_ram (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(feed_q)
  );

  pnrf_ram #(.W($bits(pnrf_pkg::item_t)), .D(ITEMS), .AW(IW)) u_item_ram (
    .clk, .we(it_we), .waddr(it_waddr), .wdata(it_wdata), .raddr(it_raddr), .rdata(item_q)
  );

  // Current head and count: from memory in decode, held afterwards
  logic [SW-1:0] cur_h, hsel;
  logic [CW-1:0] cur_c, csel;
  assign cur_h = node_vld_r[v_r] ? hc_q[HCW-1:CW] : '0;
  assign cur_c = node_vld_r[v_r] ? hc_q[CW-1:0] : '0;
  assign hsel  = (state_r == S_DEC) ? cur_h : h_r;
  assign csel  = (state_r == S_DEC) ? cur_c : c_r;

  // Ring slot arithmetic modulo the effective length
  logic [XW-1:0] hx, cx, lx, jx;
  logic [SW-1:0] h_up, h_down, oldest, s_next;
  always_comb begin
    hx     = XW'(hsel);
    cx     = XW'(csel);
    lx     = XW'(len);
    jx     = XW'(j_r) + XW'(1);
    h_up   = (hx + XW'(1) == lx) ? '0 : SW'(hx + XW'(1));
    h_down = (hx == '0) ? SW'(lx - XW'(1)) : SW'(hx - XW'(1));
    oldest = (hx >= cx) ? SW'(hx - cx) : SW'(hx + lx - cx);
    s_next = (hx >= jx) ? SW'(hx - jx) : SW'(hx + lx - jx);
  end

  logic exists, tbl_full, ev_exists;
  assign exists    = 17'(id_r) < 17'(cnt_r);
  assign tbl_full  = (cnt_r == NCW'(ITEMS));
  assign ev_exists = 17'(feed_q) < 17'(cnt_r);

  // Per-state decisions and memory controls
  pnrf_pkg::status_t dec_st;
  pnrf_pkg::item_t   dec_item;
  logic              dec_show, to_fd;
  always_comb begin
    hc_we    = 1'b0;
    hc_raddr = node_mod[in_node];
    nh       = hsel;
    nc       = csel;
    f_we     = 1'b0;
    f_wslot  = h_up;
    f_wdata  = id_r;
    f_rslot  = hsel;
    it_we    = 1'b0;
    it_waddr = IW'(id_r);
    it_raddr = IW'(in_item_id);
    dec_st   = pnrf_pkg::ST_OK;
    dec_item = item_q;
    dec_show = exists;
    to_fd    = 1'b0;
    case (state_r)
      S_DEC: begin
        case (cmd_r)
          pnrf_pkg::CMD_CREATE: begin
            dec_show = !tbl_full;
            if (tbl_full) begin
              dec_st = pnrf_pkg::ST_FULL;
            end else begin
              it_we          = 1'b1;
              it_waddr       = IW'(cnt_r);
              dec_item       = '0;
              dec_item.birth = tick_r;
            end
          end
          pnrf_pkg::CMD_SHARE: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end else begin
              it_we           = 1'b1;
              dec_item.shares = pnrf_pkg::sat_inc(item_q.shares);
              dec_item.refs   = pnrf_pkg::sat_inc(item_q.refs);
            end
          end
          pnrf_pkg::CMD_CASCADE: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end else begin
              it_we         = 1'b1;
              dec_item.casc = pnrf_pkg::sat_inc(item_q.casc);
            end
          end
          pnrf_pkg::CMD_PUSH: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end else begin
              hc_we = 1'b1;
              if (csel == '0) begin
                nh = '0; nc = CW'(1);
                f_we = 1'b1; f_wslot = '0;
              end else begin
                nh = h_up;
                f_wslot = h_up;
                if (csel < len) begin
                  nc = csel + CW'(1);
                  f_we = 1'b1;
                end else begin
                  f_rslot = h_up;
                  to_fd   = 1'b1;
                end
              end
            end
          end
          pnrf_pkg::CMD_INSERT: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end else begin
              hc_we = 1'b1;
              if (csel == '0) begin
                nh = '0; nc = CW'(1);
                f_we = 1'b1; f_wslot = '0;
              end else if (csel >= len) begin
                f_wslot = h_up;
                f_rslot = h_up;
                to_fd   = 1'b1;
              end else begin
                nc = csel + CW'(1);
                f_we = 1'b1; f_wslot = oldest;
              end
            end
          end
          pnrf_pkg::CMD_POP, pnrf_pkg::CMD_ROTATE: begin
            if (csel == '0) begin
              dec_st = pnrf_pkg::ST_EMPTY;
            end else begin
              hc_we = 1'b1;
              nh    = h_down;
              if (cmd_r == pnrf_pkg::CMD_POP) begin
                nc = csel - CW'(1);
              end
              to_fd = 1'b1;
            end
          end
          pnrf_pkg::CMD_SEARCH: begin
            to_fd = (csel != '0);
          end
          pnrf_pkg::CMD_DROP: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end else if (item_q.refs == '0) begin
              dec_st = pnrf_pkg::ST_DEAD;
            end else begin
              it_we         = 1'b1;
              dec_item.refs = item_q.refs - 16'd1;
              if (item_q.refs == 16'd1) begin
                dec_item.death = tick_r;
              end
            end
          end
          default: begin
            if (!exists) begin
              dec_st = pnrf_pkg::ST_NO_ITEM;
            end
          end
        endcase
      end
      S_FDAT: begin
        case (cmd_r)
          pnrf_pkg::CMD_PUSH, pnrf_pkg::CMD_INSERT: begin
            f_we     = 1'b1;
            f_wslot  = slot_r;
            it_raddr = IW'(feed_q);
          end
          pnrf_pkg::CMD_ROTATE: begin
            f_we    = (c_r != len);
            f_wslot = oldest;
            f_wdata = feed_q;
          end
          pnrf_pkg::CMD_SEARCH: begin
            f_rslot = s_next;
          end
          default: begin
          end
        endcase
      end
      S_EDAT: begin
        it_waddr = IW'(ev_r);
        if (item_q.refs == '0) begin
          dec_st = pnrf_pkg::ST_UNDERFLOW;
        end else begin
          it_we         = 1'b1;
          dec_item.refs = item_q.refs - 16'd1;
          if (item_q.refs == 16'd1) begin
            dec_item.death = tick_r;
          end
        end
      end
      default: begin
      end
    endcase
    it_wdata = dec_item;
  end

  assign f_waddr = FW'(32'(v_r) * FEED_DEPTH + 32'(f_wslot));
  assign f_raddr = FW'(32'(v_r) * FEED_DEPTH + 32'(f_rslot));

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      feed_length_r <= 5'd16;
      node_vld_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // result transfer frees the output register unless a new result loads it
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        feed_length_r <= cfg_feed_length;
        node_vld_r    <= '0;
      end
      if (hc_we) begin
        node_vld_r[v_r] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= pnrf_pkg::cmd_t'(in_command);
            v_r     <= node_mod[in_node];
            id_r    <= in_item_id;
            tick_r  <= in_tick;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          h_r        <= cur_h;
          c_r        <= cur_c;
          slot_r     <= f_wslot;
          j_r        <= '0;
          status_r   <= dec_st;
          found_r    <= 1'b0;
          fill_r     <= nc;
          res_item_r <= dec_show ? dec_item : '0;
          item_out_r <= (cmd_r == pnrf_pkg::CMD_CREATE && !tbl_full) ? 10'(cnt_r) : '0;
          if (cmd_r == pnrf_pkg::CMD_CREATE && !tbl_full) begin
            cnt_r <= cnt_r + NCW'(1);
          end
          state_r <= to_fd ? S_FDAT : S_OUT;
        end
        S_FDAT: begin
          case (cmd_r)
            pnrf_pkg::CMD_PUSH, pnrf_pkg::CMD_INSERT: begin
              ev_r    <= feed_q;
              state_r <= ev_exists ? S_EDAT : S_OUT;
            end
            pnrf_pkg::CMD_SEARCH: begin
              if (feed_q == id_r) begin
                found_r <= 1'b1;
                state_r <= S_OUT;
              end else if (j_r + CW'(1) == c_r) begin
                state_r <= S_OUT;
              end else begin
                j_r <= j_r + CW'(1);
              end
            end
            default: begin
              item_out_r <= feed_q;
              state_r    <= S_OUT;
            end
          endcase
        end
        S_EDAT: begin
          status_r <= dec_st;
          if (it_we && ev_r == id_r) begin
            res_item_r <= dec_item;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= status_r;
            out_item_out_r <= item_out_r;
            out_found_r    <= found_r;
            out_fill_r     <= 5'(fill_r);
            out_item_r     <= res_item_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_item_out      = out_item_out_r;
  assign out_found         = out_found_r;
  assign out_feed_fill     = out_fill_r;
  assign out_live_refs     = out_item_r.refs;
  assign out_share_count   = out_item_r.shares;
  assign out_cascade_count = out_item_r.casc;
  assign out_birth_tick    = out_item_r.birth;
  assign out_death_tick    = out_item_r.death;

endmodule
`default_nettype wire

// ===== hdl/pnrf_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module pnrf_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, read before write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
